// ===== rtl/core/lpht_pkg.sv =====
// ---------------------------------------------------------------------------
// lpht_pkg
// Shared sizes, codes and control structs for the linear probe hash table.
// ---------------------------------------------------------------------------
package lpht_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 256;
   localparam int KEY_WIDTH   = 32;
   localparam int VALUE_WIDTH = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = 9;                 // bucket count and entry count
   localparam int MOD_CNT_W   = $clog2(IDX_W);     // remainder step counter
   localparam int SLOT_W      = 2;

   localparam logic [CNT_W-1:0] BUCKETS_RESET = CNT_W'(TABLE_DEPTH);

   // request actions
   localparam logic [1:0] ACT_SEARCH = 2'd0;
   localparam logic [1:0] ACT_INSERT = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;

   // slot states
   localparam logic [SLOT_W-1:0] SLOT_EMPTY   = 2'd0;
   localparam logic [SLOT_W-1:0] SLOT_USED    = 2'd1;
   localparam logic [SLOT_W-1:0] SLOT_DELETED = 2'd2;

   // result status codes
   localparam logic [1:0] RSP_OK        = 2'd0;
   localparam logic [1:0] RSP_NOT_FOUND = 2'd1;
   localparam logic [1:0] RSP_FULL      = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic load;      // latch the request and set up the probe
      logic mod_step;  // one bit of the home bucket remainder
      logic check;     // evaluate the slot read in the previous cycle
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic             home_in_range;  // home bucket already below the count
      logic             stop;           // probe ends at this slot
      logic [CNT_W-1:0] entry_count;
   } dp_stat_type;

endpackage

// ===== rtl/core/linear_probe_hash_table_unit.sv =====
// Sequence: an accepted item runs the S_MOD remainder steps when home_index is not below the
//   bucket count, then one S_READ and S_CHECK pair per probe; the strobe is registered from the last check.
// Items: a new item is accepted only in S_IDLE, once the result of the last one is out;
//   each probe is a registered slot RAM read then a check; result stands one cycle, busy low.
// Reset (synchronous): slot valid bits cleared at once, bucket count 256, entry count zero;
//   no clearing pass. Results cannot be stalled by the receiver.
// ---------------------------------------------------------------------------
// linear_probe_hash_table_unit
// Open-addressing key/value table with linear probing and tombstones.
// ---------------------------------------------------------------------------
module linear_probe_hash_table_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_action,
   input  logic [lpht_pkg::KEY_WIDTH-1:0]    req_key,
   input  logic [lpht_pkg::VALUE_WIDTH-1:0]  req_value,
   input  logic [lpht_pkg::IDX_W-1:0]        req_home_index,
   output logic                              rsp_strobe,
   output logic                              rsp_found,
   output logic [lpht_pkg::VALUE_WIDTH-1:0]  rsp_value_out,
   output logic [lpht_pkg::IDX_W-1:0]        rsp_slot_index,
   output logic [1:0]                        rsp_status,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lpht_pkg::CNT_W-1:0]        csr_buckets_in_use
);

   lpht_pkg::dp_cmd_type  cmd;
   lpht_pkg::dp_stat_type stat;

   // register writes land between items, never with an item being accepted
   assign csr_ready = ~busy & ~start;

   lpht_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .stat       (stat)
   );

   lpht_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .csr_wr_en          (csr_valid && csr_ready),
      .csr_buckets_in_use (csr_buckets_in_use),
      .req_action         (req_action),
      .req_key            (req_key),
      .req_value          (req_value),
      .req_home_index     (req_home_index),
      .rsp_found          (rsp_found),
      .rsp_value_out      (rsp_value_out),
      .rsp_slot_index     (rsp_slot_index),
      .rsp_status         (rsp_status)
   );

`ifndef SYNTHESIS
   // an accepted item keeps the unit busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // found agrees with an ok status
   a_found_status: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_found == (rsp_status == lpht_pkg::RSP_OK)))
      else $error("found and status disagree");

   // failed results carry zero value and slot
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != lpht_pkg::RSP_OK)) |->
         ((rsp_value_out == '0) && (rsp_slot_index == '0)))
      else $error("failed result carries nonzero payload");

   // entry count never exceeds the number of slots
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      stat.entry_count <= lpht_pkg::CNT_W'(lpht_pkg::TABLE_DEPTH))
      else $error("entry count above table depth");
`endif

endmodule

// ===== rtl/core/lpht_ram.sv =====
// ---------------------------------------------------------------------------
// lpht_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
module lpht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== rtl/core/lpht_datapath.sv =====
// ---------------------------------------------------------------------------
// lpht_datapath
// Request registers, bucket remainder, slot stores, probe compare and
// result registers of the hash table.
// ---------------------------------------------------------------------------
module lpht_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  lpht_pkg::dp_cmd_type                cmd,
   output lpht_pkg::dp_stat_type               stat,
   input  logic                                csr_wr_en,
   input  logic [lpht_pkg::CNT_W-1:0]          csr_buckets_in_use,
   input  logic [1:0]                          req_action,
   input  logic [lpht_pkg::KEY_WIDTH-1:0]      req_key,
   input  logic [lpht_pkg::VALUE_WIDTH-1:0]    req_value,
   input  logic [lpht_pkg::IDX_W-1:0]          req_home_index,
   output logic                                rsp_found,
   output logic [lpht_pkg::VALUE_WIDTH-1:0]    rsp_value_out,
   output logic [lpht_pkg::IDX_W-1:0]          rsp_slot_index,
   output logic [1:0]                          rsp_status
);

   localparam int IW = lpht_pkg::IDX_W;
   localparam int CW = lpht_pkg::CNT_W;

   // configuration and bookkeeping
   logic [CW-1:0]                       buckets_ff;
   logic [CW-1:0]                       count_ff;
   logic [CW-1:0]                       count_in;
   logic [CW-1:0]                       n_eff;

   // request
   logic [1:0]                          action_ff;
   logic [lpht_pkg::KEY_WIDTH-1:0]      key_ff;
   logic [lpht_pkg::VALUE_WIDTH-1:0]    value_ff;
   logic [IW-1:0]                       home_sh_ff;

   // probe state
   logic [IW-1:0]                       idx_ff;
   logic [IW-1:0]                       idx_in;
   logic [CW-1:0]                       step_ff;
   logic [CW-1:0]                       step_nx;
   logic                                have_free_ff;
   logic [IW-1:0]                       free_idx_ff;

   // remainder step
   logic [CW-1:0]                       rem_t;
   logic [CW-1:0]                       rem_red;

   // slot stores
   logic [lpht_pkg::TABLE_DEPTH-1:0]    vld_ff;
   logic                                vld_rd_ff;
   logic [lpht_pkg::KEY_WIDTH-1:0]      key_rd;
   logic [lpht_pkg::VALUE_WIDTH-1:0]    val_rd;
   logic [lpht_pkg::SLOT_W-1:0]         st_rd;
   logic [lpht_pkg::SLOT_W-1:0]         st_eff;

   // probe decision
   logic                                is_empty;
   logic                                is_used;
   logic                                key_hit;
   logic                                take_free;
   logic                                free_any;
   logic [IW-1:0]                       free_sel;
   logic                                stop;
   logic                                commit;

   // outcome
   logic                                key_we;
   logic                                val_we;
   logic                                st_we;
   logic [IW-1:0]                       hit_addr;
   logic [lpht_pkg::SLOT_W-1:0]         st_wdata;
   logic                                cnt_inc;
   logic                                cnt_dec;
   logic                                res_found;
   logic [lpht_pkg::VALUE_WIDTH-1:0]    res_value;
   logic [IW-1:0]                       res_slot;
   logic [1:0]                          res_status;

   // effective bucket count: zero acts as one, large values saturate
   always_comb begin
      if (buckets_ff == '0) begin
         n_eff = CW'(1);
      end else if (buckets_ff > CW'(lpht_pkg::TABLE_DEPTH)) begin
         n_eff = CW'(lpht_pkg::TABLE_DEPTH);
      end else begin
         n_eff = buckets_ff;
      end
   end

   // one restoring remainder step, home bucket bits taken msb first
   assign rem_t   = {idx_ff, home_sh_ff[IW-1]};
   assign rem_red = (rem_t >= n_eff) ? (rem_t - n_eff) : rem_t;

   // slot status as seen through the valid bits
   assign st_eff    = vld_rd_ff ? st_rd : lpht_pkg::SLOT_EMPTY;
   assign is_empty  = (st_eff == lpht_pkg::SLOT_EMPTY);
   assign is_used   = (st_eff == lpht_pkg::SLOT_USED);
   assign key_hit   = is_used && (key_rd == key_ff);
   assign take_free = !have_free_ff && !is_used;
   assign free_any  = have_free_ff || take_free;
   assign free_sel  = have_free_ff ? free_idx_ff : idx_ff;
   assign step_nx   = step_ff + CW'(1);
   assign stop      = is_empty || key_hit || (step_nx == n_eff);
   assign commit    = cmd.check && stop;
   assign hit_addr  = key_hit ? idx_ff : free_sel;

   // next bucket with wrap at the bucket count
   assign idx_in = (({1'b0, idx_ff} + CW'(1)) == n_eff) ? '0 : (idx_ff + IW'(1));

   // action outcome for the slot under check
   always_comb begin
      key_we     = 1'b0;
      val_we     = 1'b0;
      st_we      = 1'b0;
      st_wdata   = lpht_pkg::SLOT_USED;
      cnt_inc    = 1'b0;
      cnt_dec    = 1'b0;
      res_found  = 1'b0;
      res_value  = '0;
      res_slot   = '0;
      res_status = lpht_pkg::RSP_NOT_FOUND;
      unique case (action_ff)
         lpht_pkg::ACT_SEARCH: begin
            if (key_hit) begin
               res_found  = 1'b1;
               res_value  = val_rd;
               res_slot   = idx_ff;
               res_status = lpht_pkg::RSP_OK;
            end
         end
         lpht_pkg::ACT_INSERT: begin
            if (key_hit) begin
               val_we     = 1'b1;
               res_found  = 1'b1;
               res_slot   = idx_ff;
               res_status = lpht_pkg::RSP_OK;
            end else if (free_any) begin
               key_we     = 1'b1;
               val_we     = 1'b1;
               st_we      = 1'b1;
               cnt_inc    = 1'b1;
               res_found  = 1'b1;
               res_slot   = free_sel;
               res_status = lpht_pkg::RSP_OK;
            end else begin
               res_status = lpht_pkg::RSP_FULL;
            end
         end
         lpht_pkg::ACT_REMOVE: begin
            if (key_hit) begin
               st_we      = 1'b1;
               st_wdata   = lpht_pkg::SLOT_DELETED;
               cnt_dec    = 1'b1;
               res_found  = 1'b1;
               res_slot   = idx_ff;
               res_status = lpht_pkg::RSP_OK;
            end
         end
         default: begin
            res_status = lpht_pkg::RSP_NOT_FOUND;
         end
      endcase
   end

   // saturating entry count
   always_comb begin
      count_in = count_ff;
      if (commit && cnt_inc && (count_ff != '1)) begin
         count_in = count_ff + CW'(1);
      end else if (commit && cnt_dec && (count_ff != '0)) begin
         count_in = count_ff - CW'(1);
      end
   end

   // control registers: bucket count, entry count, slot valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         buckets_ff <= lpht_pkg::BUCKETS_RESET;
         count_ff   <= '0;
         vld_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            buckets_ff <= csr_buckets_in_use;
         end
         count_ff <= count_in;
         if (commit && st_we) begin
            vld_ff[hit_addr] <= 1'b1;
         end
      end
   end

   // valid bit read, aligned with the RAM read data
   always_ff @(posedge clock) begin
      vld_rd_ff <= vld_ff[idx_ff];
   end

   // request and probe registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff    <= req_action;
         key_ff       <= req_key;
         value_ff     <= req_value;
         home_sh_ff   <= req_home_index;
         idx_ff       <= stat.home_in_range ? req_home_index : '0;
         step_ff      <= '0;
         have_free_ff <= 1'b0;
      end else if (cmd.mod_step) begin
         idx_ff     <= rem_red[IW-1:0];
         home_sh_ff <= {home_sh_ff[IW-2:0], 1'b0};
      end else if (cmd.check && !stop) begin
         idx_ff  <= idx_in;
         step_ff <= step_nx;
         if (take_free) begin
            have_free_ff <= 1'b1;
            free_idx_ff  <= idx_ff;
         end
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_found      <= res_found;
         rsp_value_out  <= res_value;
         rsp_slot_index <= res_slot;
         rsp_status     <= res_status;
      end
   end

   // slot stores
   lpht_ram #(
      .WIDTH (lpht_pkg::KEY_WIDTH),
      .DEPTH (lpht_pkg::TABLE_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (commit && key_we),
      .wr_addr (free_sel),
      .wr_data (key_ff),
      .rd_addr (idx_ff),
      .rd_data (key_rd)
   );

   lpht_ram #(
      .WIDTH (lpht_pkg::VALUE_WIDTH),
      .DEPTH (lpht_pkg::TABLE_DEPTH)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (commit && val_we),
      .wr_addr (hit_addr),
      .wr_data (value_ff),
      .rd_addr (idx_ff),
      .rd_data (val_rd)
   );

   lpht_ram #(
      .WIDTH (lpht_pkg::SLOT_W),
      .DEPTH (lpht_pkg::TABLE_DEPTH)
   ) u_status_ram (
      .clock   (clock),
      .wr_en   (commit && st_we),
      .wr_addr (hit_addr),
      .wr_data (st_wdata),
      .rd_addr (idx_ff),
      .rd_data (st_rd)
   );

   // status toward the controller
   assign stat.home_in_range = ({1'b0, req_home_index} < n_eff);
   assign stat.stop          = stop;
   assign stat.entry_count   = count_ff;

endmodule

// ===== rtl/core/lpht_ctrl.sv =====
// ---------------------------------------------------------------------------
// lpht_ctrl
// Sequencer: request accept, home bucket remainder, probe read and check.
// ---------------------------------------------------------------------------
module lpht_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output logic                  rsp_strobe,
   output lpht_pkg::dp_cmd_type  cmd,
   input  lpht_pkg::dp_stat_type stat
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MOD,
      S_READ,
      S_CHECK
   } state_type;

   localparam logic [lpht_pkg::MOD_CNT_W-1:0] MOD_LAST =
      lpht_pkg::MOD_CNT_W'(lpht_pkg::IDX_W - 1);

   state_type                        state_ff;
   logic [lpht_pkg::MOD_CNT_W-1:0]   mod_cnt_ff;
   logic                             busy_ff;
   logic                             strobe_ff;

   // datapath commands
   assign cmd.load     = (state_ff == S_IDLE) && start;
   assign cmd.mod_step = (state_ff == S_MOD);
   assign cmd.check    = (state_ff == S_CHECK);

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         mod_cnt_ff <= '0;
         busy_ff    <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  busy_ff    <= 1'b1;
                  mod_cnt_ff <= '0;
                  state_ff   <= stat.home_in_range ? S_READ : S_MOD;
               end
            end
            S_MOD: begin
               mod_cnt_ff <= mod_cnt_ff + lpht_pkg::MOD_CNT_W'(1);
               if (mod_cnt_ff == MOD_LAST) begin
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               if (stat.stop) begin
                  state_ff  <= S_IDLE;
                  busy_ff   <= 1'b0;
                  strobe_ff <= 1'b1;
               end else begin
                  state_ff <= S_READ;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

endmodule
